@@ hw/rtl/gga_pkg.sv @@
// Shared types, constants and helpers for the GHASH accumulator.
// Used by the top level, the GF(2^128) multiplier and the port checker.
package gga_pkg;

  localparam int BLOCK_W   = 128;
  localparam int HALF_W    = 64;
  localparam int CNT_W     = 61;
  localparam int BCNT_W    = 5;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int BLOCK_BYTES = BLOCK_W / 8;
  localparam int DIGIT_W_DEF = 8;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ASSOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEXT  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FINAL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = 1'd1;

  // reflected reduction polynomial, folded into the top byte on a carry out
  localparam logic [BLOCK_W-1:0] GF_REDUCE = {64'hE100_0000_0000_0000, 64'h0};

  localparam logic [BCNT_W-1:0] MAX_BYTES = BCNT_W'(BLOCK_BYTES);

  function automatic logic [BCNT_W-1:0] clamp_bytes(input logic [BCNT_W-1:0] n);
    clamp_bytes = (n > MAX_BYTES) ? MAX_BYTES : n;
  endfunction

  // keep the leading n bytes of a big-endian block
  function automatic logic [BLOCK_W-1:0] lead_mask(input logic [BCNT_W-1:0] n);
    logic [BLOCK_W-1:0] m;
    m = '0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (BCNT_W'(i) < n) begin
        m[BLOCK_W-1-8*i -: 8] = 8'hFF;
      end
    end
    lead_mask = m;
  endfunction

endpackage

@@ hw/rtl/gga_mul.sv @@
// Digit-serial GF(2^128) multiplier, GCM bit order, DIGIT_W bits per cycle.
// Depends on gga_pkg for widths and the reduction constant.
module gga_mul #(
  parameter int DIGIT_W = gga_pkg::DIGIT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gga_pkg::BLOCK_W-1:0] x_in,
  input  logic [gga_pkg::BLOCK_W-1:0] h_in,
  output logic [gga_pkg::BLOCK_W-1:0] z_out,
  output logic                        done
);

  localparam int STEPS = gga_pkg::BLOCK_W / DIGIT_W;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic [gga_pkg::BLOCK_W-1:0] x_sr;
  logic [gga_pkg::BLOCK_W-1:0] v;
  logic [gga_pkg::BLOCK_W-1:0] z;
  logic [gga_pkg::BLOCK_W-1:0] v_next;
  logic [gga_pkg::BLOCK_W-1:0] z_next;
  logic [CW-1:0]               cnt;
  logic                        busy;

  // one digit of x, most significant bit first
  always_comb begin
    z_next = z;
    v_next = v;
    for (int j = 0; j < DIGIT_W; j++) begin
      if (x_sr[gga_pkg::BLOCK_W-1-j]) begin
        z_next = z_next ^ v_next;
      end
      v_next = (v_next >> 1) ^ (v_next[0] ? gga_pkg::GF_REDUCE : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_sr <= x_in;
      v    <= h_in;
      z    <= '0;
    end else if (busy) begin
      x_sr <= x_sr << DIGIT_W;
      v    <= v_next;
      z    <= z_next;
    end
  end

  // hold the product after done until the next start
  assign z_out = z;

endmodule

@@ hw/rtl/ghash_gf128_accumulator.sv @@
// GHASH accumulator top level: request handling, counters, mask and tag register.
// Depends on gga_pkg and gga_mul.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | req_type, block_hi, block_lo, byte_count
//   tag     | out       | tag_valid/tag_stall  | tag_hi, tag_lo
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// A data block or finalize runs the shared multiplier through its digit steps, from
// the accept to the hand-back of the product. Finalize then loads the tag register
// in ST_PUSH, and waits there while an earlier tag is still stalled. Start and
// zero-length blocks leave the multiplier idle and do not stall the request channel.
// Synchronous reset clears the key, accumulator, counters, mask and tag valid.
// New words are taken while a tag waits to be read.
module ghash_gf128_accumulator #(
  parameter int DIGIT_W = gga_pkg::DIGIT_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [gga_pkg::REQ_W-1:0]     req_type,
  input  logic [gga_pkg::HALF_W-1:0]    block_hi,
  input  logic [gga_pkg::HALF_W-1:0]    block_lo,
  input  logic [gga_pkg::BCNT_W-1:0]    byte_count,
  output logic                          tag_valid,
  input  logic                          tag_stall,
  output logic [gga_pkg::HALF_W-1:0]    tag_hi,
  output logic [gga_pkg::HALF_W-1:0]    tag_lo,
  input  logic                          cfg_write,
  input  logic [gga_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gga_pkg::HALF_W-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                    state;
  logic                          is_final;
  logic [gga_pkg::HALF_W-1:0]    key_hi;
  logic [gga_pkg::HALF_W-1:0]    key_lo;
  logic [gga_pkg::BLOCK_W-1:0]   accum;
  logic [gga_pkg::CNT_W-1:0]     assoc_bytes;
  logic [gga_pkg::CNT_W-1:0]     text_bytes;
  logic [gga_pkg::BLOCK_W-1:0]   mask;

  logic                          accept;
  logic                          is_data;
  logic [gga_pkg::BCNT_W-1:0]    n_bytes;
  logic [gga_pkg::BLOCK_W-1:0]   data_blk;
  logic [gga_pkg::BLOCK_W-1:0]   len_blk;
  logic                          mul_start;
  logic [gga_pkg::BLOCK_W-1:0]   mul_x;
  logic [gga_pkg::BLOCK_W-1:0]   mul_z;
  logic                          mul_done;
  logic                          tag_load;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign is_data   = (req_type == gga_pkg::REQ_ASSOC) || (req_type == gga_pkg::REQ_TEXT);
  assign n_bytes   = gga_pkg::clamp_bytes(byte_count);
  assign data_blk  = {block_hi, block_lo} & gga_pkg::lead_mask(n_bytes);
  assign len_blk   = {assoc_bytes, 3'b000, text_bytes, 3'b000};
  assign mul_start = accept && ((req_type == gga_pkg::REQ_FINAL) ||
                                (is_data && (n_bytes != '0)));
  assign mul_x     = (req_type == gga_pkg::REQ_FINAL) ? (accum ^ len_blk)
                                                      : (accum ^ data_blk);
  assign tag_load  = (state == ST_PUSH) && (!tag_valid || !tag_stall);

  gga_mul #(
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x_in  (mul_x),
    .h_in  ({key_hi, key_lo}),
    .z_out (mul_z),
    .done  (mul_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        gga_pkg::CFG_KEY_HI: key_hi <= cfg_data;
        gga_pkg::CFG_KEY_LO: key_lo <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      is_final    <= 1'b0;
      accum       <= '0;
      assoc_bytes <= '0;
      text_bytes  <= '0;
      mask        <= '0;
      tag_valid   <= 1'b0;
    end else begin
      if (tag_valid && !tag_stall && !tag_load) begin
        tag_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req_type)
              gga_pkg::REQ_START: begin
                accum       <= '0;
                assoc_bytes <= '0;
                text_bytes  <= '0;
                mask        <= {block_hi, block_lo};
              end
              gga_pkg::REQ_ASSOC: begin
                if (n_bytes != '0) begin
                  assoc_bytes <= assoc_bytes + gga_pkg::CNT_W'(n_bytes);
                  is_final    <= 1'b0;
                  state       <= ST_MUL;
                end
              end
              gga_pkg::REQ_TEXT: begin
                if (n_bytes != '0) begin
                  text_bytes <= text_bytes + gga_pkg::CNT_W'(n_bytes);
                  is_final   <= 1'b0;
                  state      <= ST_MUL;
                end
              end
              default: begin
                // finalize: lengths already captured in the multiplier operand
                assoc_bytes <= '0;
                text_bytes  <= '0;
                is_final    <= 1'b1;
                state       <= ST_MUL;
              end
            endcase
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            if (is_final) begin
              state <= ST_PUSH;
            end else begin
              accum <= mul_z;
              state <= ST_IDLE;
            end
          end
        end
        ST_PUSH: begin
          if (tag_load) begin
            tag_valid <= 1'b1;
            accum     <= '0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tag_load) begin
      tag_hi <= mul_z[gga_pkg::BLOCK_W-1:gga_pkg::HALF_W] ^
                mask[gga_pkg::BLOCK_W-1:gga_pkg::HALF_W];
      tag_lo <= mul_z[gga_pkg::HALF_W-1:0] ^ mask[gga_pkg::HALF_W-1:0];
    end
  end

endmodule

@@ hw/rtl/gga_checker.sv @@
// Port-level checks for the GHASH accumulator, bound to the top level.
// Depends on gga_pkg for request codes and field widths.
module gga_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_stall,
  input logic [gga_pkg::REQ_W-1:0]  req_type,
  input logic [gga_pkg::BCNT_W-1:0] byte_count,
  input logic                       tag_valid,
  input logic                       tag_stall,
  input logic [gga_pkg::HALF_W-1:0] tag_hi,
  input logic [gga_pkg::HALF_W-1:0] tag_lo
);

  logic acc;
  assign acc = req_valid && !req_stall;

  // a stalled tag word holds
  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_stall |=> tag_valid && $stable(tag_hi) && $stable(tag_lo))
    else $error("tag word changed while stalled");

  // a nonempty data word occupies the multiplier
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    acc && (req_type == gga_pkg::REQ_ASSOC || req_type == gga_pkg::REQ_TEXT) &&
    byte_count != '0 |=> req_stall)
    else $error("data word did not engage the multiplier");

  // start completes at once
  a_start_fast: assert property (@(posedge clk) disable iff (rst)
    acc && req_type == gga_pkg::REQ_START |=> !req_stall)
    else $error("start word stalled the request channel");

  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    acc && req_type == gga_pkg::REQ_FINAL |=> req_stall)
    else $error("finalize word did not engage the multiplier");

  // a new tag appears only at the end of finalize work
  a_tag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(tag_valid) |-> $past(req_stall))
    else $error("tag produced without finalize work");

endmodule

bind ghash_gf128_accumulator gga_checker u_gga_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_stall  (req_stall),
  .req_type   (req_type),
  .byte_count (byte_count),
  .tag_valid  (tag_valid),
  .tag_stall  (tag_stall),
  .tag_hi     (tag_hi),
  .tag_lo     (tag_lo)
);
